// ===== rtl/sdre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_pkg
// Shared types, constants and helper functions of the signed radix digit
// emitter.
// ----------------------------------------------------------------------------
package sdre_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_RADIX  = 16;
    localparam int CNT_W      = 6;
    localparam int DIG_W      = 4;
    localparam int SP_W       = 5;
    localparam int RADIX_W    = 5;
    localparam int ALPHA_W    = 64;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        REG_ALPHA_LOW  = 2'd0,
        REG_ALPHA_HIGH = 2'd1,
        REG_BASE_SIZE  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha_high;
        logic [ALPHA_W-1:0] alpha_low;
        logic [RADIX_W-1:0] base_size;
    } cfg_t;

    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } cmd_t;

    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } out_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mult;
        logic [2:0]            shift;
    } recip_t;

    function automatic logic [7:0] alpha_char(input cfg_t cfg, input logic [DIG_W-1:0] idx);
        logic [2*ALPHA_W-1:0] alpha;
        alpha = {cfg.alpha_high, cfg.alpha_low};
        return alpha[{idx, 3'b000} +: 8];
    endfunction

    // floor(2^(31+s) / r) with s = ceil(log2 r); the estimate is low by at most one
    function automatic recip_t recip(input logic [RADIX_W-1:0] r);
        recip_t res;
        res.mult  = 32'h8000_0000;
        res.shift = 3'd1;
        case (r)
            5'd3:    begin res.mult = 32'(35'h2_0000_0000 / 35'd3);  res.shift = 3'd2; end
            5'd4:    begin res.mult = 32'h8000_0000;                 res.shift = 3'd2; end
            5'd5:    begin res.mult = 32'(35'h4_0000_0000 / 35'd5);  res.shift = 3'd3; end
            5'd6:    begin res.mult = 32'(35'h4_0000_0000 / 35'd6);  res.shift = 3'd3; end
            5'd7:    begin res.mult = 32'(35'h4_0000_0000 / 35'd7);  res.shift = 3'd3; end
            5'd8:    begin res.mult = 32'h8000_0000;                 res.shift = 3'd3; end
            5'd9:    begin res.mult = 32'(36'h8_0000_0000 / 36'd9);  res.shift = 3'd4; end
            5'd10:   begin res.mult = 32'(36'h8_0000_0000 / 36'd10); res.shift = 3'd4; end
            5'd11:   begin res.mult = 32'(36'h8_0000_0000 / 36'd11); res.shift = 3'd4; end
            5'd12:   begin res.mult = 32'(36'h8_0000_0000 / 36'd12); res.shift = 3'd4; end
            5'd13:   begin res.mult = 32'(36'h8_0000_0000 / 36'd13); res.shift = 3'd4; end
            5'd14:   begin res.mult = 32'(36'h8_0000_0000 / 36'd14); res.shift = 3'd4; end
            5'd15:   begin res.mult = 32'(36'h8_0000_0000 / 36'd15); res.shift = 3'd4; end
            5'd16:   begin res.mult = 32'h8000_0000;                 res.shift = 3'd4; end
            default: begin res.mult = 32'h8000_0000;                 res.shift = 3'd1; end
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/signed_radix_digit_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter
// Converts signed 32-bit numbers to text in a configured base, one character
// per result transfer.
// ----------------------------------------------------------------------------
// Numbers enter through a two-entry queue and are converted one at a time.
// Each digit needs a reciprocal multiply and a correction step in the
// divide unit, and each character goes into the result queue whenever
// it has room. Numbers written while the radix or alphabet is invalid
// are taken and dropped.
// Write the configuration registers only while no conversion is pending.
module signed_radix_digit_emitter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [sdre_pkg::VALUE_BITS-1:0] value,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      character,
    output logic                            final_char,
    input  logic                            wr_en,
    input  logic [1:0]                      wr_index,
    input  logic [sdre_pkg::ALPHA_W-1:0]    wr_data
);
    import sdre_pkg::*;

    cfg_t cfg_reg;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    logic out_push;
    out_t out_in;
    out_t out_head;
    logic out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_ALPHA_LOW:  cfg_reg.alpha_low  <= wr_data;
                REG_ALPHA_HIGH: cfg_reg.alpha_high <= wr_data;
                REG_BASE_SIZE:  cfg_reg.base_size  <= wr_data[RADIX_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    sdre_front u_front (
        .push     (push),
        .value    (value),
        .full     (full),
        .cfg      (cfg_reg),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    sdre_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd_in),
        .rd      (cmd_pop),
        .rd_data (cmd_out),
        .q_full  (cmd_full),
        .q_empty (cmd_empty)
    );

    sdre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_in)
    );

    sdre_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (out_push),
        .wr_data (out_in),
        .pop     (pop),
        .empty   (empty),
        .q_full  (out_full),
        .rd_data (out_head)
    );

    assign character  = out_head.character;
    assign final_char = out_head.final_char;

    a_no_cmd_on_bad_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && cfg_reg.base_size < RADIX_W'(2)) |-> !cmd_push)
        else $error("number queued with radix below two");

    a_minus_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && !out_full && out_in.character == CH_MINUS) |-> !out_in.final_char)
        else $error("minus sign marked as last character");

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("back end took a number from an empty queue");

endmodule

// ===== rtl/sdre_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_front
// Accepts numbers, checks the configured radix and alphabet, drops numbers
// that cannot be converted and splits the rest into sign and magnitude.
// ----------------------------------------------------------------------------
module sdre_front (
    input  logic                            push,
    input  logic [sdre_pkg::VALUE_BITS-1:0] value,
    output logic                            full,
    input  sdre_pkg::cfg_t                  cfg,
    input  logic                            cmd_full,
    output logic                            cmd_push,
    output sdre_pkg::cmd_t                  cmd
);
    import sdre_pkg::*;

    logic [7:0] chars [MAX_RADIX];
    logic       radix_ok;

    always_comb
    begin
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            chars[i] = alpha_char(cfg, DIG_W'(i));
        end
    end

    always_comb
    begin
        radix_ok = (cfg.base_size >= RADIX_W'(2)) && (cfg.base_size <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            if (RADIX_W'(i) < cfg.base_size)
            begin
                if (chars[i] == CH_PLUS || chars[i] == CH_MINUS)
                begin
                    radix_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++)
                begin
                    if (RADIX_W'(j) < cfg.base_size && chars[i] == chars[j])
                    begin
                        radix_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full && radix_ok;
    assign cmd.neg  = value[VALUE_BITS-1];
    assign cmd.mag  = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

endmodule

// ===== rtl/sdre_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_cmd_queue
// Two-entry queue of classified numbers between front and back.
// ----------------------------------------------------------------------------
module sdre_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  sdre_pkg::cmd_t wr_data,
    input  logic           rd,
    output sdre_pkg::cmd_t rd_data,
    output logic           q_full,
    output logic           q_empty
);
    import sdre_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== rtl/sdre_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_out_queue
// Two-entry result queue; decouples character generation from the consumer.
// ----------------------------------------------------------------------------
module sdre_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  sdre_pkg::out_t wr_data,
    input  logic           pop,
    output logic           empty,
    output logic           q_full,
    output sdre_pkg::out_t rd_data
);
    import sdre_pkg::*;

    out_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== rtl/sdre_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdre_back
// Converts one magnitude at a time: sign first, then reciprocal multiply and
// correction per digit into a digit stack, then digits most significant first.
// ----------------------------------------------------------------------------
module sdre_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sdre_pkg::cfg_t cfg,
    input  logic           cmd_empty,
    input  sdre_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           out_full,
    output logic           out_push,
    output sdre_pkg::out_t out_data
);
    import sdre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_MUL,
        ST_FIX,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   quot_reg, quot_next;
    logic [2*VALUE_BITS-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DIG_W-1:0]        stack_reg [VALUE_BITS];

    recip_t                  rcp;
    logic [VALUE_BITS-1:0]   q_est;
    logic [VALUE_BITS+RADIX_W-1:0] back_prod;
    logic [VALUE_BITS+RADIX_W-1:0] rem_full;
    logic [RADIX_W:0]        rem;
    logic [RADIX_W:0]        radix_ext;
    logic                    rem_over;
    logic [VALUE_BITS-1:0]   q_fix;
    logic [DIG_W-1:0]        digit;
    logic                    stack_we;
    logic [CNT_W-1:0]        cnt_inc;
    logic [SP_W-1:0]         rd_idx;

    assign rcp       = recip(cfg.base_size);
    assign q_est     = VALUE_BITS'(prod_reg >> (6'd31 + 6'(rcp.shift)));
    assign back_prod = (VALUE_BITS+RADIX_W)'(q_est) * (VALUE_BITS+RADIX_W)'(cfg.base_size);
    assign rem_full  = (VALUE_BITS+RADIX_W)'(quot_reg) - back_prod;
    assign rem       = rem_full[RADIX_W:0];
    assign radix_ext = {1'b0, cfg.base_size};
    assign rem_over  = (rem >= radix_ext);
    assign q_fix     = rem_over ? (q_est + VALUE_BITS'(1)) : q_est;
    assign digit     = rem_over ? DIG_W'(rem - radix_ext) : DIG_W'(rem);
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign rd_idx    = SP_W'(cnt_reg - CNT_W'(1));
    assign stack_we  = (state_reg == ST_FIX);

    always_comb
    begin
        state_next          = state_reg;
        quot_next           = quot_reg;
        prod_next           = prod_reg;
        cnt_next            = cnt_reg;
        cmd_pop             = 1'b0;
        out_push            = 1'b0;
        out_data.character  = CH_MINUS;
        out_data.final_char = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    quot_next  = cmd.mag;
                    cnt_next   = '0;
                    state_next = cmd.neg ? ST_SIGN : ST_MUL;
                end
            end
            ST_SIGN:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = (2*VALUE_BITS)'(quot_reg) * (2*VALUE_BITS)'(rcp.mult);
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                quot_next = q_fix;
                cnt_next  = cnt_inc;
                if (q_fix == '0 || cnt_inc == CNT_W'(VALUE_BITS))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                out_data.character  = alpha_char(cfg, stack_reg[rd_idx]);
                out_data.final_char = (cnt_reg == CNT_W'(1));
                if (!out_full)
                begin
                    out_push = 1'b1;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_reg[SP_W'(cnt_reg)] <= digit;
        end
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            quot_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            quot_reg  <= quot_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
